// ===== rtl/tpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// TLB probe/fill cost model package
// Shared constants, configuration register codes and the configuration type.
// ----------------------------------------------------------------------------
package tpfc_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_ADDR_BITS   = 32;

   // Smallest page shift; the tag holds ADDR_BITS - MIN_SHIFT bits.
   localparam int MIN_SHIFT = 10;

   // Width of entry counts (wired + free, and up to 128 entries).
   localparam int NUM_W = 8;

   // Statistics counter width.
   localparam int CNT_W = 48;

   // Reported entry index width.
   localparam int OUT_IDX_W = 6;

   // Result tdata: index, then four counters, padded to whole bytes.
   localparam int RSP_FIELDS_W = OUT_IDX_W + 4 * CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Miss accounting.
   localparam logic [6:0] PERCENT_FULL = 7'd100;
   localparam logic [7:0] FIRSTCOST    = 8'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PAGE_SHIFT   = 3'd0,
      REG_PAIR_MAPPING = 3'd1,
      REG_WIRED_COUNT  = 3'd2,
      REG_FREE_COUNT   = 3'd3,
      REG_HIT_PERCENT  = 3'd4,
      REG_FILL_PENALTY = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [4:0] page_shift;
      logic       pair_mapping;
      logic [5:0] wired_count;
      logic [6:0] free_count;
      logic [6:0] cache_hit_percent;
      logic [7:0] fill_penalty;
   } cfg_type;

   localparam logic [4:0] RST_PAGE_SHIFT   = 5'd12;
   localparam logic       RST_PAIR_MAPPING = 1'b0;
   localparam logic [5:0] RST_WIRED_COUNT  = 6'd7;
   localparam logic [6:0] RST_FREE_COUNT   = 7'd56;
   localparam logic [6:0] RST_HIT_PERCENT  = 7'd97;
   localparam logic [7:0] RST_FILL_PENALTY = 8'd10;

endpackage

// ===== rtl/tpfc_front.sv =====
// ----------------------------------------------------------------------------
// TLB front end
// Accepts request beats, forms the page number and holds the classified item
// until the queue takes it.
// ----------------------------------------------------------------------------
module tpfc_front #(
   parameter int ADDR_BITS = tpfc_pkg::DEF_ADDR_BITS,
   parameter int TAG_W     = ADDR_BITS - tpfc_pkg::MIN_SHIFT,
   parameter int REQ_W     = ((ADDR_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tpfc_pkg::cfg_type    cfg,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 push_valid,
   input  logic                 push_ready,
   output logic [TAG_W:0]       push_data
);

   logic                 valid_ff, valid_in;
   logic                 op_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [4:0]           shift;
   logic [ADDR_BITS-1:0] shifted;
   logic [TAG_W-1:0]     page;
   logic                 take;

   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;
   assign push_valid = valid_ff;
   assign push_data  = {op_ff, tag_ff};

   always_comb begin
      shift   = (cfg.page_shift < 5'(tpfc_pkg::MIN_SHIFT)) ? 5'(tpfc_pkg::MIN_SHIFT)
                                                            : cfg.page_shift;
      shifted = req_tdata[ADDR_BITS-1:0] >> shift;
      page    = shifted[TAG_W-1:0];
      // Even/odd page pairs share one tag.
      if (cfg.pair_mapping) begin
         page[0] = 1'b0;
      end
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff  <= req_tuser;
         tag_ff <= page;
      end
   end

endmodule

// ===== rtl/tpfc_queue.sv =====
// ----------------------------------------------------------------------------
// TLB item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module tpfc_queue #(
   parameter int WIDTH = tpfc_pkg::DEF_ADDR_BITS - tpfc_pkg::MIN_SHIFT + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = tpfc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = fill_ff != FILL_W'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tpfc_back.sv =====
// ----------------------------------------------------------------------------
// TLB back end
// Holds the entries, runs probes and fills, keeps the statistics counters and
// the result register.
// ----------------------------------------------------------------------------
module tpfc_back #(
   parameter int MAX_ENTRIES = tpfc_pkg::DEF_MAX_ENTRIES,
   parameter int TAG_W       = tpfc_pkg::DEF_ADDR_BITS - tpfc_pkg::MIN_SHIFT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tpfc_pkg::cfg_type                 cfg,
   input  logic                              item_valid,
   input  logic [TAG_W:0]                    item_data,
   output logic                              item_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_tuser,
   output logic [tpfc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int NUM_W = tpfc_pkg::NUM_W;
   localparam int CNT_W = tpfc_pkg::CNT_W;
   localparam int RST_SUM = int'(tpfc_pkg::RST_WIRED_COUNT) + int'(tpfc_pkg::RST_FREE_COUNT);
   localparam int RST_USED = (RST_SUM > MAX_ENTRIES) ? MAX_ENTRIES : RST_SUM;
   localparam logic [IDX_W-1:0] PTR_RST = IDX_W'(RST_USED - 1);
   localparam int PAD_W = tpfc_pkg::RSP_DATA_W - tpfc_pkg::RSP_FIELDS_W;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SEARCH = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [TAG_W-1:0]       tag_ff [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [MAX_ENTRIES-1:0] match_ff, match_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic [6:0]             mc_ff, mc_in;
   logic [CNT_W-1:0]       refs_ff, refs_in, fills_ff, fills_in;
   logic [CNT_W-1:0]       misses_ff, misses_in, cost_ff, cost_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   out_hit_ff;
   logic [tpfc_pkg::OUT_IDX_W-1:0] out_idx_ff;
   logic [CNT_W-1:0]       out_refs_ff, out_fills_ff, out_misses_ff, out_cost_ff;

   logic                   item_op;
   logic [TAG_W-1:0]       item_tag;
   logic                   out_free;
   logic                   start_probe, start_fill, write_entry, load_out;
   logic [NUM_W-1:0]       used_sum, used, used_m1, wired;
   logic [IDX_W-1:0]       slot, enc_idx, idx_sel;
   logic [NUM_W-1:0]       idx_wide;
   logic [6:0]             mc_next, miss_gap;
   logic [13:0]            mc_prod;
   logic                   miss_step;
   logic [7:0]             penalty;

   assign item_op  = item_data[TAG_W];
   assign item_tag = item_data[TAG_W-1:0];
   assign out_free = !out_valid_ff || rsp_tready;

   assign start_probe = (state_ff == ST_IDLE) && item_valid && out_free && !item_op;
   assign start_fill  = (state_ff == ST_IDLE) && item_valid && out_free && item_op;
   assign item_pop    = start_probe || start_fill;

   // Entries in use and the replaceable range.
   always_comb begin
      used_sum = NUM_W'(cfg.wired_count) + NUM_W'(cfg.free_count);
      used     = (used_sum > NUM_W'(MAX_ENTRIES)) ? NUM_W'(MAX_ENTRIES) : used_sum;
      used_m1  = used - 1'b1;
      wired    = NUM_W'(cfg.wired_count);
   end

   // Tag compare against every entry in use; registered before the encoder.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (tag_ff[i] == item_tag) && (NUM_W'(i) < used);
      end
   end

   // Lowest matching entry wins.
   always_comb begin
      enc_idx = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            enc_idx = IDX_W'(i);
         end
      end
   end

   // Fill: pick the slot, then step the pointer down inside the replaceable range.
   always_comb begin
      write_entry = start_fill && (wired < used);
      if ((NUM_W'(ptr_ff) < wired) || (NUM_W'(ptr_ff) >= used)) begin
         slot = IDX_W'(used_m1);
      end else begin
         slot = ptr_ff;
      end
      ptr_in   = ptr_ff;
      valid_in = valid_ff;
      if (write_entry) begin
         valid_in[slot] = 1'b1;
         ptr_in = (NUM_W'(slot) == wired) ? IDX_W'(used_m1) : slot - 1'b1;
      end
   end

   // Memory miss accounting from the assumed cache hit rate.
   always_comb begin
      mc_next   = mc_ff + 1'b1;
      miss_gap  = tpfc_pkg::PERCENT_FULL - cfg.cache_hit_percent;
      mc_prod   = 14'(mc_next) * 14'(miss_gap);
      mc_in     = mc_ff;
      miss_step = 1'b0;
      if (start_fill) begin
         if (cfg.cache_hit_percent > tpfc_pkg::PERCENT_FULL) begin
            mc_in     = '0;
            miss_step = 1'b1;
         end else if (cfg.cache_hit_percent != tpfc_pkg::PERCENT_FULL) begin
            if (mc_prod >= 14'(tpfc_pkg::PERCENT_FULL)) begin
               mc_in     = '0;
               miss_step = 1'b1;
            end else begin
               mc_in = mc_next;
            end
         end
      end
      penalty = (cfg.fill_penalty == '0) ? tpfc_pkg::FIRSTCOST : cfg.fill_penalty;
   end

   always_comb begin
      refs_in   = start_probe ? refs_ff + 1'b1 : refs_ff;
      fills_in  = start_fill ? fills_ff + 1'b1 : fills_ff;
      misses_in = miss_step ? misses_ff + 1'b1 : misses_ff;
      cost_in   = start_fill ? cost_ff + CNT_W'(penalty) : cost_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_probe) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A probe result is loaded in the search cycle; the register is empty then
   // because the probe only left the queue while it was free.
   assign load_out = start_fill || (state_ff == ST_SEARCH);

   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      idx_sel  = start_fill ? (write_entry ? slot : '0) : (|match_ff ? enc_idx : '0);
      idx_wide = NUM_W'(idx_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         ptr_ff       <= PTR_RST;
         mc_ff        <= '0;
         refs_ff      <= '0;
         fills_ff     <= '0;
         misses_ff    <= '0;
         cost_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         mc_ff        <= mc_in;
         refs_ff      <= refs_in;
         fills_ff     <= fills_in;
         misses_ff    <= misses_in;
         cost_ff      <= cost_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_entry) begin
         tag_ff[slot] <= item_tag;
      end
      if (start_probe) begin
         match_ff <= match_in;
      end
      if (load_out) begin
         out_hit_ff    <= !start_fill && (|match_ff);
         out_idx_ff    <= idx_wide[tpfc_pkg::OUT_IDX_W-1:0];
         out_refs_ff   <= refs_in;
         out_fills_ff  <= fills_in;
         out_misses_ff <= misses_in;
         out_cost_ff   <= cost_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = {PAD_W'(0), out_cost_ff, out_misses_ff, out_fills_ff, out_refs_ff,
                        out_idx_ff};

endmodule

// ===== rtl/tlb_probe_fill_cost_model.sv =====
// ----------------------------------------------------------------------------
// TLB probe/fill cost model
// Fully associative TLB with wired entries, down-counter replacement and
// fill cost statistics.
//
// Channel  Direction  Handshake              Payload
// req_     in         req_tvalid/req_tready  tuser: opcode; tdata: address
// rsp_     out        rsp_tvalid/rsp_tready  tuser: hit; tdata: index, counters
// csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// A fill is done in the idle state; a probe registers the tag compare over all
// entries, then runs the priority encoder in the search state. The back-end
// state machine sets the rate: one fill per cycle while the result register is
// free, and no new item while in search. A beat passes the front register and
// the queue before the back end. Synchronous reset clears the valid bits, the
// counters and the queue. Either side may stall; the queue decouples them.
// ----------------------------------------------------------------------------
module tlb_probe_fill_cost_model #(
   parameter int MAX_ENTRIES = tpfc_pkg::DEF_MAX_ENTRIES,
   parameter int ADDR_BITS   = tpfc_pkg::DEF_ADDR_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic                                  req_tuser,  // opcode
   input  logic [((ADDR_BITS + 7) / 8) * 8-1:0]  req_tdata,  // address, zero pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tuser,  // hit
   // entry_index, total_refs, total_fills, memory_misses, fill_cost, zero pad
   output logic [tpfc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tpfc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tpfc_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int TAG_W = ADDR_BITS - tpfc_pkg::MIN_SHIFT;
   localparam int REQ_W = ((ADDR_BITS + 7) / 8) * 8;

   tpfc_pkg::cfg_type cfg_ff, cfg_in;
   logic              push_valid, push_ready, pop_valid, pop;
   logic [TAG_W:0]    push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (tpfc_pkg::csr_reg_type'(csr_index))
            tpfc_pkg::REG_PAGE_SHIFT:   cfg_in.page_shift        = csr_data[4:0];
            tpfc_pkg::REG_PAIR_MAPPING: cfg_in.pair_mapping      = csr_data[0];
            tpfc_pkg::REG_WIRED_COUNT:  cfg_in.wired_count       = csr_data[5:0];
            tpfc_pkg::REG_FREE_COUNT:   cfg_in.free_count        = csr_data[6:0];
            tpfc_pkg::REG_HIT_PERCENT:  cfg_in.cache_hit_percent = csr_data[6:0];
            tpfc_pkg::REG_FILL_PENALTY: cfg_in.fill_penalty      = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_shift        <= tpfc_pkg::RST_PAGE_SHIFT;
         cfg_ff.pair_mapping      <= tpfc_pkg::RST_PAIR_MAPPING;
         cfg_ff.wired_count       <= tpfc_pkg::RST_WIRED_COUNT;
         cfg_ff.free_count        <= tpfc_pkg::RST_FREE_COUNT;
         cfg_ff.cache_hit_percent <= tpfc_pkg::RST_HIT_PERCENT;
         cfg_ff.fill_penalty      <= tpfc_pkg::RST_FILL_PENALTY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpfc_front #(
      .ADDR_BITS (ADDR_BITS),
      .TAG_W     (TAG_W),
      .REQ_W     (REQ_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tpfc_queue #(
      .WIDTH (TAG_W + 1)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   tpfc_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .TAG_W       (TAG_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (pop_valid),
      .item_data  (pop_data),
      .item_pop   (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/sv/tlb_cost_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB probe/fill cost checker
// Watches the request, result and register channels of the TLB cost model.
// It keeps its own copy of the tag store, the replacement pointer and the
// statistics, and computes the outcome of every accepted request beat. Each
// accepted result beat is checked field by field against the oldest pending
// outcome. It reports the mismatch count and the number of outcomes still
// pending.
// ----------------------------------------------------------------------------
module tlb_cost_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic                                 req_tuser,  // opcode
   input  logic [31:0]                          req_tdata,  // address
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 rsp_tuser,  // hit
   // entry_index, total_refs, total_fills, memory_misses, fill_cost, zero pad
   input  logic [tpfc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [tpfc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tpfc_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                   error_count,
   output int                                   pending_count
);

   import tpfc_pkg::*;

   localparam logic OP_FILL = 1'b1;
   localparam int   SLOTS   = DEF_MAX_ENTRIES;
   localparam int   TAG_W   = DEF_ADDR_BITS - MIN_SHIFT;

   typedef struct {
      logic             hit;
      logic [5:0]       index;
      logic [CNT_W-1:0] refs;
      logic [CNT_W-1:0] fills;
      logic [CNT_W-1:0] misses;
      logic [CNT_W-1:0] cost;
   } tlb_outcome_type;

   cfg_type          setting;
   logic [TAG_W-1:0] slot_tag [SLOTS];
   logic             slot_valid [SLOTS];
   int               replace_ptr;
   int               miss_step;
   logic [CNT_W-1:0] probe_total;
   logic [CNT_W-1:0] fill_total;
   logic [CNT_W-1:0] miss_total;
   logic [CNT_W-1:0] cost_total;
   tlb_outcome_type  pending_outcomes[$];
   int               mismatches = 0;

   assign error_count = mismatches;

   task automatic report_error(input string msg);
      $display("%0t ns: ERROR %s", $time, msg);
      mismatches++;
   endtask

   function automatic int slots_in_use();
      int n;
      n = int'(setting.wired_count) + int'(setting.free_count);
      return (n > SLOTS) ? SLOTS : n;
   endfunction

   task automatic reset_tlb();
      int n;
      setting.page_shift        = RST_PAGE_SHIFT;
      setting.pair_mapping      = RST_PAIR_MAPPING;
      setting.wired_count       = RST_WIRED_COUNT;
      setting.free_count        = RST_FREE_COUNT;
      setting.cache_hit_percent = RST_HIT_PERCENT;
      setting.fill_penalty      = RST_FILL_PENALTY;
      for (int i = 0; i < SLOTS; i++) begin
         slot_tag[i]   = '0;
         slot_valid[i] = 1'b0;
      end
      n = slots_in_use();
      replace_ptr = (n > 0) ? n - 1 : 0;
      miss_step   = 0;
      probe_total = '0;
      fill_total  = '0;
      miss_total  = '0;
      cost_total  = '0;
   endtask

   task automatic write_setting(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_PAGE_SHIFT:   setting.page_shift        = value[4:0];
         REG_PAIR_MAPPING: setting.pair_mapping      = value[0];
         REG_WIRED_COUNT:  setting.wired_count       = value[5:0];
         REG_FREE_COUNT:   setting.free_count        = value[6:0];
         REG_HIT_PERCENT:  setting.cache_hit_percent = value[6:0];
         REG_FILL_PENALTY: setting.fill_penalty      = value;
         default: ;
      endcase
   endtask

   // Computes the outcome of one access and advances the TLB state.
   task automatic tlb_access(input logic op, input logic [31:0] addr,
                             output tlb_outcome_type res);
      int          shift;
      int          n;
      int          wired_n;
      int          pct;
      logic [31:0] page;
      res.hit   = 1'b0;
      res.index = '0;
      // Shifts below the minimum would overflow the tag, so they are raised.
      shift   = (setting.page_shift < MIN_SHIFT) ? MIN_SHIFT : int'(setting.page_shift);
      page    = addr >> shift;
      if (setting.pair_mapping)
         page[0] = 1'b0;
      n       = slots_in_use();
      wired_n = int'(setting.wired_count);
      if (op != OP_FILL) begin
         probe_total = probe_total + 1'b1;
         for (int i = 0; i < n; i++) begin
            if (!res.hit && slot_valid[i] && slot_tag[i] == page[TAG_W-1:0]) begin
               res.hit   = 1'b1;
               res.index = i[5:0];
            end
         end
      end else begin
         // With every slot in use wired down, nothing gets written.
         if (wired_n < n) begin
            if (replace_ptr < wired_n || replace_ptr >= n)
               replace_ptr = n - 1;
            res.index               = replace_ptr[5:0];
            slot_tag[replace_ptr]   = page[TAG_W-1:0];
            slot_valid[replace_ptr] = 1'b1;
            replace_ptr = (replace_ptr == wired_n) ? n - 1 : replace_ptr - 1;
         end
         fill_total = fill_total + 1'b1;
         pct = int'(setting.cache_hit_percent);
         if (pct > int'(PERCENT_FULL)) begin
            miss_step  = 0;
            miss_total = miss_total + 1'b1;
         end else if (pct != int'(PERCENT_FULL)) begin
            miss_step++;
            if (miss_step * (int'(PERCENT_FULL) - pct) >= int'(PERCENT_FULL)) begin
               miss_step  = 0;
               miss_total = miss_total + 1'b1;
            end
         end
         cost_total = cost_total +
                      ((setting.fill_penalty == '0) ? FIRSTCOST : setting.fill_penalty);
      end
      res.refs   = probe_total;
      res.fills  = fill_total;
      res.misses = miss_total;
      res.cost   = cost_total;
   endtask

   always @(posedge clock) begin : monitor
      tlb_outcome_type want;
      tlb_outcome_type got;
      if (reset) begin
         reset_tlb();
         pending_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready)
            write_setting(csr_reg_type'(csr_index), csr_data);
         if (rsp_tvalid && rsp_tready) begin
            got.hit    = rsp_tuser;
            got.index  = rsp_tdata[OUT_IDX_W-1:0];
            got.refs   = rsp_tdata[OUT_IDX_W + 0*CNT_W +: CNT_W];
            got.fills  = rsp_tdata[OUT_IDX_W + 1*CNT_W +: CNT_W];
            got.misses = rsp_tdata[OUT_IDX_W + 2*CNT_W +: CNT_W];
            got.cost   = rsp_tdata[OUT_IDX_W + 3*CNT_W +: CNT_W];
            if (pending_outcomes.size() == 0) begin
               report_error("result beat with no request pending");
            end else begin
               want = pending_outcomes.pop_front();
               if (got.hit !== want.hit)
                  report_error($sformatf("hit: got %0b, expected %0b", got.hit, want.hit));
               if (got.index !== want.index)
                  report_error($sformatf("entry_index: got %0d, expected %0d",
                                         got.index, want.index));
               if (got.refs !== want.refs)
                  report_error($sformatf("total_refs: got %0h, expected %0h",
                                         got.refs, want.refs));
               if (got.fills !== want.fills)
                  report_error($sformatf("total_fills: got %0h, expected %0h",
                                         got.fills, want.fills));
               if (got.misses !== want.misses)
                  report_error($sformatf("memory_misses: got %0h, expected %0h",
                                         got.misses, want.misses));
               if (got.cost !== want.cost)
                  report_error($sformatf("fill_cost: got %0h, expected %0h",
                                         got.cost, want.cost));
            end
         end
         if (req_tvalid && req_tready) begin
            tlb_access(req_tuser, req_tdata, want);
            pending_outcomes.push_back(want);
         end
      end
      pending_count <= pending_outcomes.size();
   end

endmodule

// ===== tb/sv/tb_tlb_probe_fill_cost_model.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB probe/fill cost model testbench
// Drives probes and fills through the request stream in random bursts while
// the result side stalls on changing patterns. A directed opening covers the
// corner settings, then random phases reprogram the registers between runs of
// mostly related addresses so that hits, refills and evictions are frequent.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tlb_probe_fill_cost_model;

   import tpfc_pkg::*;

   localparam int   ADDR_W          = ((DEF_ADDR_BITS + 7) / 8) * 8;
   localparam logic OP_PROBE        = 1'b0;
   localparam logic OP_FILL         = 1'b1;
   localparam int   RANDOM_PHASES   = 8;
   localparam int   ITEMS_PER_PHASE = 100;
   localparam int   IDLE_LIMIT      = 2000;
   localparam int   END_CYCLES      = 20;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_PERIODIC,
      READY_SPARSE
   } ready_style_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = 1'b0;
   logic [ADDR_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   csr_reg_type           csr_index  = REG_PAGE_SHIFT;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   int              error_count;
   int              pending_count;
   int              idle_cycles = 0;
   int              burst_left  = 0;
   int              mode_cycles = 0;
   int              ready_tick  = 0;
   int              eff_shift   = 12;
   ready_style_type ready_style = READY_ALWAYS;
   logic [31:0]     recent_fills[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tlb_probe_fill_cost_model uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tlb_cost_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tuser     (rsp_tuser),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // The result side switches between stall styles, picked at random.
   always @(posedge clock) begin
      ready_tick <= ready_tick + 1;
      if (mode_cycles == 0) begin
         ready_style <= ready_style_type'($urandom_range(0, 3));
         mode_cycles <= $urandom_range(20, 200);
      end else begin
         mode_cycles <= mode_cycles - 1;
      end
      case (ready_style)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_COIN:     rsp_tready <= $urandom_range(0, 1);
         READY_PERIODIC: rsp_tready <= (ready_tick % 7) >= 3;
         default:        rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_access(input logic op, input logic [31:0] addr);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0)
            gap = 0;
         else if ($urandom_range(0, 7) == 0)
            gap = $urandom_range(8, 30);
         else
            gap = $urandom_range(1, 3);
         repeat (gap) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= addr;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (op == OP_FILL) begin
         recent_fills.push_back(addr);
         if (recent_fills.size() > 16)
            void'(recent_fills.pop_front());
      end
   endtask

   // Most probes reuse a page filled lately, so the hit path gets real traffic.
   task automatic send_random_access();
      int          roll;
      logic [31:0] addr;
      logic [31:0] base;
      roll = $urandom_range(0, 99);
      addr = $urandom;
      if (recent_fills.size() != 0) begin
         base = recent_fills[$urandom_range(0, recent_fills.size() - 1)];
         if (roll < 10)
            addr = base;
         else if (roll >= 45 && roll < 80)
            addr = base ^ ($urandom & 32'h3FF);
         else if (roll >= 80 && roll < 88)
            addr = base ^ (32'h1 << eff_shift);
      end
      send_access((roll < 45) ? OP_FILL : OP_PROBE, addr);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic apply_setting(input cfg_type s);
      write_csr(REG_PAGE_SHIFT,   {3'b0, s.page_shift});
      write_csr(REG_PAIR_MAPPING, {7'b0, s.pair_mapping});
      write_csr(REG_WIRED_COUNT,  {2'b0, s.wired_count});
      write_csr(REG_FREE_COUNT,   {1'b0, s.free_count});
      write_csr(REG_HIT_PERCENT,  {1'b0, s.cache_hit_percent});
      write_csr(REG_FILL_PENALTY, s.fill_penalty);
      csr_valid <= 1'b0;
      eff_shift = (s.page_shift < MIN_SHIFT) ? MIN_SHIFT : int'(s.page_shift);
   endtask

   // Every request returns one result, so an empty checker queue means idle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   function automatic cfg_type make_setting(input int shift, input int pair, input int wired_n,
                                            input int free_n, input int pct, input int pen);
      cfg_type s;
      s.page_shift        = shift[4:0];
      s.pair_mapping      = pair[0];
      s.wired_count       = wired_n[5:0];
      s.free_count        = free_n[6:0];
      s.cache_hit_percent = pct[6:0];
      s.fill_penalty      = pen[7:0];
      return s;
   endfunction

   function automatic cfg_type random_setting();
      int shift;
      int wired_n;
      int free_n;
      int pct;
      int pen;
      shift = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(10, 16);
      case ($urandom_range(0, 3))
         0:       wired_n = 0;
         1:       wired_n = $urandom_range(0, 8);
         2:       wired_n = $urandom_range(0, 63);
         default: wired_n = $urandom_range(60, 63);
      endcase
      case ($urandom_range(0, 9))
         0:       free_n = $urandom_range(0, 127);
         1, 2:    free_n = $urandom_range(17, 64);
         default: free_n = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
         0:       pct = 0;
         1:       pct = 100;
         2, 3:    pct = $urandom_range(101, 127);
         default: pct = $urandom_range(0, 100);
      endcase
      pen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255);
      return make_setting(shift, $urandom_range(0, 1), wired_n, free_n, pct, pen);
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: empty entries holding a zero tag must not hit.
      send_access(OP_PROBE, 32'h0000_0000);
      send_access(OP_FILL,  32'h0000_0000);
      send_access(OP_PROBE, 32'h0000_0FFF);
      send_access(OP_PROBE, 32'hFFFF_FFFF);
      send_access(OP_FILL,  32'hFFFF_FFFF);
      send_access(OP_PROBE, 32'hFFFF_F000);
      send_access(OP_FILL,  32'h0000_0000);
      send_access(OP_PROBE, 32'h0000_0123);
      wait_idle();

      // Undersized shift, pair mapping, single slot with the pointer out of
      // range, full hit rate and a zero penalty.
      apply_setting(make_setting(5, 1, 0, 1, 100, 0));
      send_access(OP_FILL,  32'h0000_0C00);
      send_access(OP_PROBE, 32'h0000_0800);
      send_access(OP_FILL,  32'hAAAA_A400);
      send_access(OP_PROBE, 32'h0000_0C00);
      wait_idle();

      // Largest shift, slot count clipped to the table size, hit rate over 100.
      apply_setting(make_setting(31, 0, 63, 64, 127, 255));
      send_access(OP_FILL,  32'h8000_0000);
      send_access(OP_PROBE, 32'h8000_0000);
      send_access(OP_PROBE, 32'h0000_0000);
      send_access(OP_FILL,  32'h7FFF_FFFF);
      wait_idle();

      // All slots in use are wired, so fills write nothing; zero hit rate.
      apply_setting(make_setting(16, 0, 10, 0, 0, 1));
      send_access(OP_FILL,  32'h1234_5678);
      send_access(OP_FILL,  32'hFFFF_FFFF);
      send_access(OP_PROBE, 32'h0000_0000);
      wait_idle();

      // No slots in use at all.
      apply_setting(make_setting(10, 1, 0, 0, 99, 128));
      send_access(OP_FILL,  32'h5555_5555);
      send_access(OP_PROBE, 32'h5555_5555);
      wait_idle();

      // Largest free count.
      apply_setting(make_setting(12, 0, 1, 127, 50, 10));
      send_access(OP_FILL,  32'hC0DE_0000);
      send_access(OP_PROBE, 32'hC0DE_0ABC);
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_setting(random_setting());
         repeat (ITEMS_PER_PHASE)
            send_random_access();
         wait_idle();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
